/* sv/mpq_pkg.sv */
// Shared types and constants for the max priority queue.
`default_nettype none
package mpq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int TDATA_W = ((DATA_W + PRIO_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_POP    = 2'd2,
        OP_DRAIN  = 2'd3
    } op_t;

    // one stored entry
    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } slot_t;

    // one result transaction
    typedef struct packed {
        slot_t slot;
        logic  found;
        logic  rejected;
        logic  last;
    } res_t;

endpackage
`default_nettype wire

/* sv/max_priority_queue_unit.sv */
// Bounded max-priority queue, oldest first among equal priorities.
//
// Each transaction on the slave side carries one operation in s_tuser: insert,
// peek, pop or drain. Entries live in arrival order in a 16-entry one-read
// one-write memory with a registered read. Insert and any operation on an empty
// store are answered from the idle state. Peek scans the store one entry per
// cycle. Pop adds a pass that closes the gap, one entry per cycle. Drain repeats
// pop until the store is empty and emits one result per entry, best first, with
// m_tlast on the final one. The single memory read port paces both passes.
// Results go through a pending register and an output register, so the block
// takes the next transaction while one result still waits on m_tready.
`default_nettype none
module max_priority_queue_unit
    import mpq_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [TDATA_W-1:0] s_tdata,   // [31:0] item_data, [39:32] item_priority
    input  wire  [1:0]         s_tuser,   // [1:0] kind
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] out_data, [39:32] out_priority
    output logic [1:0]         m_tuser,   // [0] found, [1] rejected
    output logic               m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HOLD  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    slot_t mem [DEPTH];
    slot_t rd_q;

    logic [OCC_W-1:0] occ_reg, occ_next;
    op_t              op_reg, op_next;
    logic [IDX_W-1:0] iss_reg, iss_next;
    logic             iss_on_reg, iss_on_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    slot_t            best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;

    res_t res_reg, res_next;
    logic res_vld_reg, res_vld_next;
    res_t m_reg;
    logic m_tvalid_reg, m_tvalid_next;

    logic             rd_en;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    slot_t            mem_wd;
    logic             res_wr;
    logic             out_load;
    logic             in_acc;
    logic [OCC_W-1:0] occ_m1;
    logic [IDX_W-1:0] last_idx;
    logic             take_cur;
    slot_t            cand;
    logic [IDX_W-1:0] cand_idx;
    slot_t            in_slot;
    op_t              in_op;

    assign out_load = res_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE) && (!res_vld_reg || out_load);
    assign in_acc   = s_tvalid && s_tready;
    assign occ_m1   = occ_reg - OCC_W'(1);
    assign last_idx = occ_m1[IDX_W-1:0];
    assign in_slot  = slot_t'(s_tdata[DATA_W+PRIO_W-1:0]);
    assign in_op    = op_t'(s_tuser);

    // scan candidate includes the entry arriving this cycle
    assign take_cur = (rd_idx_reg == '0) || (rd_q.prio > best_reg.prio);
    assign cand     = take_cur ? rd_q : best_reg;
    assign cand_idx = take_cur ? rd_idx_reg : best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_q <= mem[iss_reg];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        op_next       = op_reg;
        iss_next      = iss_reg;
        iss_on_next   = iss_on_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        res_wr        = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = occ_reg[IDX_W-1:0];
        mem_wd        = in_slot;
        rd_en         = 1'b0;

        // read issue shared by scan and shift
        if ((state_reg == S_SCAN || state_reg == S_SHIFT) && iss_on_reg)
        begin
            rd_en = 1'b1;
            if (iss_reg == last_idx)
            begin
                iss_on_next = 1'b0;
            end
            else
            begin
                iss_next = iss_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = in_op;
                    res_next = '0;
                    res_next.last = 1'b1;
                    if (in_op == OP_INSERT)
                    begin
                        res_wr = 1'b1;
                        if (in_slot.prio == '0 || occ_reg == OCC_W'(DEPTH))
                        begin
                            res_next.rejected = 1'b1;
                        end
                        else
                        begin
                            mem_we   = 1'b1;
                            occ_next = occ_reg + OCC_W'(1);
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        res_wr = 1'b1;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                // wait for the pending slot so a scan can always finish
                if (!res_vld_reg)
                begin
                    state_next  = S_SCAN;
                    iss_next    = '0;
                    iss_on_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg)
                begin
                    best_next     = cand;
                    best_idx_next = cand_idx;
                    if (rd_idx_reg == last_idx)
                    begin
                        res_wr            = 1'b1;
                        res_next.slot     = cand;
                        res_next.found    = 1'b1;
                        res_next.rejected = 1'b0;
                        res_next.last     = (op_reg != OP_DRAIN) || (occ_reg == OCC_W'(1));
                        if (op_reg == OP_PEEK)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (cand_idx == last_idx)
                        begin
                            // best is the newest entry: nothing to move
                            occ_next = occ_m1;
                            if (op_reg == OP_DRAIN && occ_m1 != '0)
                            begin
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next  = S_SHIFT;
                            iss_next    = cand_idx + IDX_W'(1);
                            iss_on_next = 1'b1;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = rd_idx_reg - IDX_W'(1);
                    mem_wd = rd_q;
                    if (rd_idx_reg == last_idx)
                    begin
                        occ_next = occ_m1;
                        if (op_reg == OP_DRAIN && occ_m1 != '0)
                        begin
                            state_next = S_HOLD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_wr)
        begin
            res_vld_next = 1'b1;
        end
        else if (out_load)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            iss_on_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            iss_on_reg   <= iss_on_next;
            rd_vld_reg   <= rd_en;
            res_vld_reg  <= res_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        iss_reg      <= iss_next;
        rd_idx_reg   <= iss_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        if (res_wr)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            m_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({m_reg.slot.prio, m_reg.slot.data});
    assign m_tuser  = {m_reg.rejected, m_reg.found};
    assign m_tlast  = m_reg.last;

endmodule
`default_nettype wire

/* sv/mpq_checker.sv */
// Port-level checker for the max priority queue, bound to the top level.
`default_nettype none
module mpq_port_checker
    import mpq_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               m_tvalid,
    input wire               m_tready,
    input wire [TDATA_W-1:0] m_tdata,
    input wire [1:0]         m_tuser,
    input wire               m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_found_xor_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both found and rejected");

    a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("rejected insert not marked last");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("payload not zero without a served entry");

    a_found_prio: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[DATA_W+PRIO_W-1:DATA_W] != '0)
        else $error("served entry has zero priority");

endmodule

bind max_priority_queue_unit mpq_port_checker u_mpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
